// File: sv/sca_pkg.sv
// ----------------------------------------------------------------------------
// sca_pkg: shared types, codes and keymaps
// Request and response structs, set-1 scancode constants and the plain and
// shifted keymaps for the scancode decoder.
// ----------------------------------------------------------------------------
package sca_pkg;

	// default character FIFO depth
	localparam int unsigned FIFO_DEPTH_DEF = 512;

	// request opcodes
	localparam logic OP_SCAN = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// modifier flag bits
	localparam int unsigned FLAG_CTRL  = 0;
	localparam int unsigned FLAG_SHIFT = 1;
	localparam int unsigned FLAG_ALT   = 2;

	// modifier patterns that select a keymap
	localparam logic [2:0] MODS_NONE       = 3'b000;
	localparam logic [2:0] MODS_SHIFT_ONLY = 3'b010;
	localparam logic [2:0] MODS_CTRL_ONLY  = 3'b001;

	// set-1 scancodes
	localparam logic [7:0] SC_EXT_PREFIX = 8'hE0;
	localparam logic [7:0] SC_LSHIFT_MK  = 8'h2A;
	localparam logic [7:0] SC_RSHIFT_MK  = 8'h36;
	localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
	localparam logic [7:0] SC_CTRL_MK    = 8'h1D;
	localparam logic [7:0] SC_CTRL_BRK   = 8'h9D;
	localparam logic [7:0] SC_ALT_MK     = 8'h38;
	localparam logic [7:0] SC_ALT_BRK    = 8'hB8;
	localparam logic [7:0] SC_KEY_D      = 8'h20;

	// ctrl+D gives end of transmission
	localparam logic [6:0] CH_EOT = 7'd4;

	typedef struct packed {
		logic       opcode;
		logic [7:0] scan_byte;
	} sca_req_t;

	typedef struct packed {
		logic [6:0] read_char;
		logic       read_valid;
		logic       char_dropped;
		logic [2:0] modifiers;
	} sca_rsp_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;   // capture the incoming request
		logic exec;   // carry out the captured request
	} sca_cmd_t;

	// unshifted keymap
	function automatic logic [6:0] plain_map(input logic [6:0] code);
		logic [6:0] ch;
		case (code)
			7'd1:  ch = 7'h1B;
			7'd2:  ch = 7'h31;
			7'd3:  ch = 7'h32;
			7'd4:  ch = 7'h33;
			7'd5:  ch = 7'h34;
			7'd6:  ch = 7'h35;
			7'd7:  ch = 7'h36;
			7'd8:  ch = 7'h37;
			7'd9:  ch = 7'h38;
			7'd10: ch = 7'h39;
			7'd11: ch = 7'h30;
			7'd12: ch = 7'h2B;
			7'd14: ch = 7'h08;
			7'd15: ch = 7'h09;
			7'd16: ch = 7'h71;
			7'd17: ch = 7'h77;
			7'd18: ch = 7'h65;
			7'd19: ch = 7'h72;
			7'd20: ch = 7'h74;
			7'd21: ch = 7'h79;
			7'd22: ch = 7'h75;
			7'd23: ch = 7'h69;
			7'd24: ch = 7'h6F;
			7'd25: ch = 7'h70;
			7'd26: ch = 7'h5B;
			7'd27: ch = 7'h5D;
			7'd28: ch = 7'h0A;
			7'd30: ch = 7'h61;
			7'd31: ch = 7'h73;
			7'd32: ch = 7'h64;
			7'd33: ch = 7'h66;
			7'd34: ch = 7'h67;
			7'd35: ch = 7'h68;
			7'd36: ch = 7'h6A;
			7'd37: ch = 7'h6B;
			7'd38: ch = 7'h6C;
			7'd39: ch = 7'h3B;
			7'd40: ch = 7'h27;
			7'd41: ch = 7'h3C;
			7'd43: ch = 7'h5C;
			7'd44: ch = 7'h7A;
			7'd45: ch = 7'h78;
			7'd46: ch = 7'h63;
			7'd47: ch = 7'h76;
			7'd48: ch = 7'h62;
			7'd49: ch = 7'h6E;
			7'd50: ch = 7'h6D;
			7'd51: ch = 7'h2C;
			7'd52: ch = 7'h2E;
			7'd53: ch = 7'h2D;
			7'd55: ch = 7'h2A;
			7'd57: ch = 7'h20;
			7'd74: ch = 7'h2D;
			7'd78: ch = 7'h2B;
			7'd86: ch = 7'h3C;
			default: ch = 7'h00;
		endcase
		return ch;
	endfunction

	// shifted keymap
	function automatic logic [6:0] shift_map(input logic [6:0] code);
		logic [6:0] ch;
		case (code)
			7'd1:  ch = 7'h1B;
			7'd2:  ch = 7'h21;
			7'd3:  ch = 7'h22;
			7'd4:  ch = 7'h23;
			7'd6:  ch = 7'h25;
			7'd7:  ch = 7'h26;
			7'd8:  ch = 7'h2F;
			7'd9:  ch = 7'h28;
			7'd10: ch = 7'h29;
			7'd11: ch = 7'h3D;
			7'd12: ch = 7'h3F;
			7'd13: ch = 7'h60;
			7'd14: ch = 7'h08;
			7'd15: ch = 7'h09;
			7'd16: ch = 7'h51;
			7'd17: ch = 7'h57;
			7'd18: ch = 7'h45;
			7'd19: ch = 7'h52;
			7'd20: ch = 7'h54;
			7'd21: ch = 7'h59;
			7'd22: ch = 7'h55;
			7'd23: ch = 7'h49;
			7'd24: ch = 7'h4F;
			7'd25: ch = 7'h50;
			7'd26: ch = 7'h41;
			7'd27: ch = 7'h41;
			7'd28: ch = 7'h0A;
			7'd30: ch = 7'h41;
			7'd31: ch = 7'h53;
			7'd32: ch = 7'h44;
			7'd33: ch = 7'h46;
			7'd34: ch = 7'h47;
			7'd35: ch = 7'h48;
			7'd36: ch = 7'h4A;
			7'd37: ch = 7'h4B;
			7'd38: ch = 7'h4C;
			7'd39: ch = 7'h4F;
			7'd40: ch = 7'h27;
			7'd41: ch = 7'h3E;
			7'd43: ch = 7'h2A;
			7'd44: ch = 7'h5A;
			7'd45: ch = 7'h58;
			7'd46: ch = 7'h43;
			7'd47: ch = 7'h56;
			7'd48: ch = 7'h42;
			7'd49: ch = 7'h4E;
			7'd50: ch = 7'h4D;
			7'd51: ch = 7'h3B;
			7'd52: ch = 7'h3A;
			7'd53: ch = 7'h5F;
			7'd55: ch = 7'h2A;
			7'd57: ch = 7'h20;
			7'd74: ch = 7'h2D;
			7'd78: ch = 7'h2B;
			7'd86: ch = 7'h3E;
			default: ch = 7'h00;
		endcase
		return ch;
	endfunction

endpackage

// File: sv/sca_ctrl.sv
// ----------------------------------------------------------------------------
// sca_ctrl: request sequencer
// Takes one request, has the datapath carry it out, then holds the response
// until the far side takes it.
// ----------------------------------------------------------------------------
module sca_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output sca_pkg::sca_cmd_t cmd
);
	import sca_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_RESP = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state and commands
	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		rsp_valid = 1'b0;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				cmd.load  = req_valid;
				if (req_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_RESP;
			end
			S_RESP: begin
				rsp_valid = 1'b1;
				if (!rsp_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: sv/sca_dp.sv
// ----------------------------------------------------------------------------
// sca_dp: decoder and character FIFO datapath
// Request register, modifier flags, keymap decode, ring FIFO with its
// pointers, and the response register.
// ----------------------------------------------------------------------------
module sca_dp #(
	parameter int unsigned FIFO_DEPTH = sca_pkg::FIFO_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sca_pkg::sca_cmd_t cmd,
	input  sca_pkg::sca_req_t req,
	output sca_pkg::sca_rsp_t rsp
);
	import sca_pkg::*;

	localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(FIFO_DEPTH - 1);

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		return (p == LAST_SLOT) ? '0 : p + 1'b1;
	endfunction

	sca_req_t         req_q;
	sca_rsp_t         rsp_q;
	logic [2:0]       mods_q;
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [6:0]       mem [FIFO_DEPTH];
	logic [6:0]       rdata_q;

	logic [2:0]       mods_d;
	logic [6:0]       ch;
	logic             is_pop;
	logic             fifo_empty;
	logic             fifo_full;
	logic             push;
	logic             pop;
	sca_rsp_t         rsp_d;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	// modifier update and keymap decode
	always_comb begin
		mods_d = mods_q;
		ch     = 7'h00;
		unique case (req_q.scan_byte) inside
			SC_EXT_PREFIX: ;
			SC_LSHIFT_MK, SC_RSHIFT_MK:   mods_d[FLAG_SHIFT] = 1'b1;
			SC_LSHIFT_BRK, SC_RSHIFT_BRK: mods_d[FLAG_SHIFT] = 1'b0;
			SC_CTRL_MK:                   mods_d[FLAG_CTRL]  = 1'b1;
			SC_CTRL_BRK:                  mods_d[FLAG_CTRL]  = 1'b0;
			SC_ALT_MK:                    mods_d[FLAG_ALT]   = 1'b1;
			SC_ALT_BRK:                   mods_d[FLAG_ALT]   = 1'b0;
			default: begin
				// break codes of ordinary keys give nothing
				if (!req_q.scan_byte[7]) begin
					if (mods_q == MODS_NONE) begin
						ch = plain_map(req_q.scan_byte[6:0]);
					end else if (mods_q == MODS_SHIFT_ONLY) begin
						ch = shift_map(req_q.scan_byte[6:0]);
					end else if (mods_q == MODS_CTRL_ONLY &&
							req_q.scan_byte == SC_KEY_D) begin
						ch = CH_EOT;
					end
				end
			end
		endcase
	end

	// FIFO flags and response
	assign is_pop     = (req_q.opcode == OP_POP);
	assign fifo_empty = (wp_q == rp_q);
	assign fifo_full  = (next_slot(wp_q) == rp_q);
	assign pop        = cmd.exec && is_pop && !fifo_empty;
	assign push       = cmd.exec && !is_pop && (ch != 7'h00) && !fifo_full;

	always_comb begin
		rsp_d              = '0;
		rsp_d.modifiers    = mods_q;
		if (is_pop) begin
			if (!fifo_empty) begin
				rsp_d.read_char  = rdata_q;
				rsp_d.read_valid = 1'b1;
			end
		end else begin
			rsp_d.modifiers    = mods_d;
			rsp_d.char_dropped = (ch != 7'h00) && fifo_full;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rsp_q <= rsp_d;
		end
	end

	// character store; read data registered from the head slot
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= ch;
		end
		rdata_q <= mem[rp_q];
	end

	// pointers and modifier flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mods_q <= '0;
			wp_q   <= '0;
			rp_q   <= '0;
		end else begin
			if (cmd.exec && !is_pop) begin
				mods_q <= mods_d;
			end
			if (push) begin
				wp_q <= next_slot(wp_q);
			end
			if (pop) begin
				rp_q <= next_slot(rp_q);
			end
		end
	end

	assign rsp = rsp_q;

endmodule

// File: sv/scancode_to_ascii_fifo.sv
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo: set-1 scancode decoder with character FIFO
// Scancode requests update the modifiers and push decoded characters;
// pop requests take one character back out.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   sca_req_t (opcode, scan_byte)
//   rsp      out        rsp_valid/rsp_stall   sca_rsp_t (char, valid, drop, mods)
//
// A request is accepted in idle, carried out in the next cycle (decode, FIFO
// access, read data from the store's registered port) and its response is
// offered the cycle after and held until it is taken.
// Reset clears the modifiers and both pointers; the store needs no clearing.
// req_stall stays high from acceptance until the response has been taken.
// ----------------------------------------------------------------------------
module scancode_to_ascii_fifo #(
	parameter int unsigned FIFO_DEPTH = sca_pkg::FIFO_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sca_pkg::sca_req_t req,
	input  logic              req_valid,
	output logic              req_stall,
	output sca_pkg::sca_rsp_t rsp,
	output logic              rsp_valid,
	input  logic              rsp_stall
);
	import sca_pkg::*;

	sca_cmd_t cmd;

	sca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	sca_dp #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
